// ===== hdl/assert_macros.svh =====
// assertion macros shared by the alpha mask remap rtl
// expects clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define AMTR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("amtr assertion failed");

// next-cycle implication, off during reset
`define AMTR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("amtr assertion failed");

`endif

// ===== hdl/amtr_pkg.sv =====
// shared types and constants of the alpha mask remap unit
// no dependencies
`default_nettype none
package amtr_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int TABLE_DEPTH   = 256;
  localparam int TBL_AW        = $clog2(TABLE_DEPTH);

  // 16.16 ramp numerator, 65536 * 255
  localparam int SCALE_W = 24;
  localparam logic [SCALE_W-1:0] SCALE_NUM = SCALE_W'(65536 * 255);

  localparam int ROW_W   = 13;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic MODE_TABLE = 1'b0;
  localparam logic MODE_CLIP  = 1'b1;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MODE      = 2'd0,
    REG_CLIP_LOW  = 2'd1,
    REG_CLIP_HIGH = 2'd2,
    REG_ROW_WIDTH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic               busy;
    logic [SCALE_W-1:0] scale;
  } scale_stat_t;

endpackage
`default_nettype wire

// ===== hdl/amtr_scale.sv =====
// iterative divider for the clip ramp scale, one quotient bit per cycle
// depends on amtr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module amtr_scale
  import amtr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [7:0]  divisor,
  output scale_stat_t      stat
);

  localparam int CNT_W = $clog2(SCALE_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [7:0]         dreg;
  logic [7:0]         rem;
  logic [SCALE_W-1:0] q;

  logic [8:0] rem_sh;
  logic       fits;

  // restoring step: shift in the next dividend bit from the top of q
  assign rem_sh = {rem, q[SCALE_W-1]};
  assign fits   = rem_sh >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(SCALE_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= cnt != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dreg <= divisor;
      rem  <= '0;
      q    <= SCALE_NUM;
    end else if (busy) begin
      rem <= fits ? 8'(rem_sh - {1'b0, dreg}) : rem_sh[7:0];
      q   <= {q[SCALE_W-2:0], fits};
    end
  end

  assign stat.busy  = busy;
  assign stat.scale = q;

  // smallest possible scale is 65536, so a finished quotient is never zero
  `AMTR_ASSERT_IMP(a_scale_nonzero, $fell(busy), q != '0)

endmodule
`default_nettype wire

// ===== hdl/alpha_mask_table_remap_unit.sv =====
// path: an accepted pixel is registered in stage 1, then in stage 2, then in the
// output register; throughput: one request per cycle while result_stall is low;
// a row end holds the input while padding bytes leave the output register
// reset: control cleared, table reads as identity through per-entry valid bits;
// after reset and after each clip_low/clip_high write the input stalls while
// the ramp scale is divided out one bit per cycle
`default_nettype none
`include "assert_macros.svh"
module alpha_mask_table_remap_unit
  import amtr_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // request channel
  input  wire logic              pixel_valid,
  output logic                   pixel_stall,
  input  wire logic              command,
  input  wire logic [7:0]        alpha_in,
  input  wire logic [7:0]        entry_index,
  input  wire logic [7:0]        entry_value,
  // result channel
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic [7:0]             alpha_out,
  output logic                   is_padding,
  output logic                   row_last,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // configuration registers
  logic            mode;
  logic [7:0]      clip_low;
  logic [7:0]      clip_high;
  logic [ROW_W-1:0] row_width;
  logic            scale_dirty;

  logic     cfg_wr;
  reg_idx_t cfg_idx;
  logic     clip_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign clip_wr = cfg_wr && (cfg_idx == REG_CLIP_LOW || cfg_idx == REG_CLIP_HIGH);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_TABLE;
      clip_low    <= 8'd0;
      clip_high   <= 8'd255;
      row_width   <= ROW_W'(1);
      scale_dirty <= 1'b1;
    end else begin
      scale_dirty <= clip_wr;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_MODE:      mode      <= pwdata[0];
          REG_CLIP_LOW:  clip_low  <= pwdata[7:0];
          REG_CLIP_HIGH: clip_high <= pwdata[7:0];
          REG_ROW_WIDTH: row_width <= pwdata[ROW_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:      prdata = DATA_W'(mode);
      REG_CLIP_LOW:  prdata = DATA_W'(clip_low);
      REG_CLIP_HIGH: prdata = DATA_W'(clip_high);
      REG_ROW_WIDTH: prdata = DATA_W'(row_width);
      default:       prdata = '0;
    endcase
  end

  // cleaned ramp bounds
  logic [7:0] hi_c, lo_c, span;
  assign hi_c = (clip_high == 8'd0) ? 8'd1 : clip_high;
  assign lo_c = (clip_low >= hi_c) ? 8'(hi_c - 8'd1) : clip_low;
  assign span = 8'(hi_c - lo_c);

  scale_stat_t scale_st;

  amtr_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .start   (scale_dirty),
    .divisor (span),
    .stat    (scale_st)
  );

  // pipeline control
  logic       s1_valid, s2_valid;
  logic [1:0] pad_left;
  logic       adv_out, s2_free, s1_free;
  logic       acc, pix_acc, wr_acc;

  assign adv_out     = !result_valid || !result_stall;
  assign s2_free     = !s2_valid || (adv_out && pad_left == 2'd0);
  assign s1_free     = !s1_valid || s2_free;
  assign pixel_stall = !s1_free || scale_dirty || scale_st.busy;
  assign acc         = pixel_valid && !pixel_stall;
  assign pix_acc     = acc && (command == CMD_PIXEL);
  assign wr_acc      = acc && (command == CMD_WRITE);

  // row position
  logic [CW-1:0] column_count;
  logic [31:0]   eff_w;
  logic          row_end;
  logic [1:0]    pad_n;

  always_comb begin
    if (row_width == '0) begin
      eff_w = 32'd1;
    end else if (32'(row_width) > 32'(MAX_WIDTH)) begin
      eff_w = 32'(MAX_WIDTH);
    end else begin
      eff_w = 32'(row_width);
    end
  end

  assign row_end = !((32'(column_count) + 32'd1) < eff_w);
  assign pad_n   = 2'(2'd0 - eff_w[1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
    end else if (pix_acc) begin
      column_count <= row_end ? '0 : CW'(column_count + 1'b1);
    end
  end

  // remap table, entries never written read as identity
  logic [7:0]             tbl_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tbl_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_vld <= '0;
    end else if (wr_acc) begin
      tbl_vld[entry_index] <= 1'b1;
    end
  end

  // stage 1: table read and ramp offset
  logic [7:0] s1_rd, s1_alpha, s1_diff;
  logic       s1_hit, s1_le, s1_ge, s1_mode, s1_end;
  logic [1:0] s1_pad;

  always_ff @(posedge clk) begin
    if (wr_acc) begin
      tbl_mem[entry_index] <= entry_value;
    end
    if (pix_acc) begin
      s1_rd    <= tbl_mem[alpha_in];
      s1_hit   <= tbl_vld[alpha_in];
      s1_alpha <= alpha_in;
      s1_diff  <= 8'(alpha_in - lo_c);
      s1_le    <= alpha_in <= lo_c;
      s1_ge    <= alpha_in >= hi_c;
      s1_mode  <= mode;
      s1_end   <= row_end;
      s1_pad   <= pad_n;
    end
  end

  // stage 2: ramp product and table value select
  logic [31:0] s2_prod;
  logic [7:0]  s2_tval;
  logic        s2_le, s2_ge, s2_mode, s2_end;
  logic [1:0]  s2_pad;

  always_ff @(posedge clk) begin
    if (s1_valid && s2_free) begin
      s2_prod <= {8'd0, scale_st.scale} * {24'd0, s1_diff};
      s2_tval <= s1_hit ? s1_rd : s1_alpha;
      s2_le   <= s1_le;
      s2_ge   <= s1_ge;
      s2_mode <= s1_mode;
      s2_end  <= s1_end;
      s2_pad  <= s1_pad;
    end
  end

  logic [31:0] rounded;
  logic [7:0]  s2_val;
  assign rounded = s2_prod + 32'd32768;

  always_comb begin
    if (s2_mode == MODE_TABLE) begin
      s2_val = s2_tval;
    end else if (s2_le) begin
      s2_val = 8'd0;
    end else if (s2_ge) begin
      s2_val = 8'd255;
    end else begin
      s2_val = rounded[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
      pad_left     <= 2'd0;
    end else begin
      if (pix_acc) begin
        s1_valid <= 1'b1;
      end else if (s2_free) begin
        s1_valid <= 1'b0;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (adv_out) begin
        if (pad_left != 2'd0) begin
          result_valid <= 1'b1;
          pad_left     <= pad_left - 2'd1;
        end else if (s2_valid) begin
          result_valid <= 1'b1;
          pad_left     <= s2_end ? s2_pad : 2'd0;
        end else begin
          result_valid <= 1'b0;
        end
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (adv_out) begin
      if (pad_left != 2'd0) begin
        alpha_out  <= 8'd0;
        is_padding <= 1'b1;
        row_last   <= pad_left == 2'd1;
      end else if (s2_valid) begin
        alpha_out  <= s2_val;
        is_padding <= 1'b0;
        row_last   <= s2_end && (s2_pad == 2'd0);
      end
    end
  end

  `AMTR_ASSERT_IMP(a_pad_needs_valid, pad_left != 2'd0, result_valid)
  `AMTR_ASSERT_IMP(a_pad_is_zero, result_valid && is_padding, alpha_out == 8'd0)
  `AMTR_ASSERT_NXT(a_pad_follows, result_valid && !result_stall && pad_left != 2'd0,
                   result_valid && is_padding)
  `AMTR_ASSERT_IMP(a_no_accept_in_divide, pixel_valid && !pixel_stall,
                   !scale_st.busy && !scale_dirty)

endmodule
`default_nettype wire

// ===== tb/tb_alpha_mask_table_remap_unit.sv =====
`timescale 1ns / 100ps
// testbench for alpha_mask_table_remap_unit: directed and random requests with
// results checked against an in-bench remap predictor, registers set over apb
// depends on amtr_pkg and the rtl of the unit
module tb_alpha_mask_table_remap_unit
  import amtr_pkg::*;
();

  typedef struct packed {
    logic [7:0] alpha;
    logic       pad;
    logic       last;
  } remap_byte_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              pixel_valid = 1'b0;
  logic              pixel_stall;
  cmd_t              command = CMD_PIXEL;
  logic [7:0]        alpha_in = '0;
  logic [7:0]        entry_index = '0;
  logic [7:0]        entry_value = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [7:0]        alpha_out;
  logic              is_padding;
  logic              row_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // predictor state
  logic [7:0]       remap_lut [TABLE_DEPTH];
  logic [11:0]      column_pos;
  logic             mode_q;
  logic [7:0]       clip_low_q;
  logic [7:0]       clip_high_q;
  logic [ROW_W-1:0] row_width_q;

  remap_byte_t expected_bytes[$];
  int          mismatches = 0;
  int          requests_sent = 0;
  int          burst_left = 0;
  bit          pace_sender = 1'b0;
  bit          pace_receiver = 1'b0;
  bit          start_hold = 1'b0;
  int          hold_left = 0;
  int          stall_run = 0;
  bit          stall_on = 1'b0;
  logic [7:0]  last_entry = '0;

  alpha_mask_table_remap_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .command      (command),
    .alpha_in     (alpha_in),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .alpha_out    (alpha_out),
    .is_padding   (is_padding),
    .row_last     (row_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [7:0] clip_ramp(input logic [7:0] p);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] scale;
    hi = 32'(clip_high_q);
    lo = 32'(clip_low_q);
    if (hi == 0) hi = 1;
    if (lo >= hi) lo = hi - 1;
    if (32'(p) <= lo) return 8'd0;
    if (32'(p) >= hi) return 8'd255;
    scale = (32'd65536 * 32'd255) / (hi - lo);
    return 8'((scale * (32'(p) - lo) + 32'd32768) >> 16);
  endfunction

  function automatic int row_span();
    int w;
    w = int'(row_width_q);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  task automatic predict_remap(input cmd_t c, input logic [7:0] a, input logic [7:0] idx,
                               input logic [7:0] val);
    logic [7:0] v;
    int         w;
    int         pad;
    if (c == CMD_WRITE) begin
      remap_lut[idx] = val;
    end else begin
      v = (mode_q == MODE_CLIP) ? clip_ramp(a) : remap_lut[a];
      w = row_span();
      if (int'(column_pos) + 1 < w) begin
        column_pos = column_pos + 12'd1;
        expected_bytes.push_back('{alpha: v, pad: 1'b0, last: 1'b0});
      end else begin
        // row end, a width lowered mid-row lands here too
        column_pos = '0;
        pad = ((w + 3) & ~3) - w;
        expected_bytes.push_back('{alpha: v, pad: 1'b0, last: (pad == 0)});
        for (int i = 0; i < pad; i++)
          expected_bytes.push_back('{alpha: 8'd0, pad: 1'b1, last: (i + 1 == pad)});
      end
    end
  endtask

  task automatic send_request(input cmd_t c, input logic [7:0] a, input logic [7:0] idx,
                              input logic [7:0] val);
    int gap;
    if (pace_sender && burst_left <= 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk);
        pixel_valid <= 1'b0;
      end
    end
    @(negedge clk);
    pixel_valid <= 1'b1;
    command     <= c;
    alpha_in    <= a;
    entry_index <= idx;
    entry_value <= val;
    do @(posedge clk); while (pixel_stall);
    burst_left--;
    requests_sent++;
    predict_remap(c, a, idx, val);
  endtask

  task automatic send_pixel(input logic [7:0] a);
    send_request(CMD_PIXEL, a, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_entry(input logic [7:0] idx, input logic [7:0] val);
    last_entry = idx;
    send_request(CMD_WRITE, 8'($urandom), idx, val);
  endtask

  task automatic drain_results();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    // table writes give no result and are not held in the pipe
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
    logic [31:0] rd;
    logic [31:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_MODE: begin
        mode_q = v[0];
        want = 32'(v[0]);
      end
      REG_CLIP_LOW: begin
        clip_low_q = v[7:0];
        want = 32'(v[7:0]);
      end
      REG_CLIP_HIGH: begin
        clip_high_q = v[7:0];
        want = 32'(v[7:0]);
      end
      default: begin
        row_width_q = v[ROW_W-1:0];
        want = 32'(v[ROW_W-1:0]);
      end
    endcase
    if (rd !== want) report_mismatch(r.name(), rd, want);
  endtask

  task automatic test_identity_table();
    send_pixel(8'd0);
    send_pixel(8'd255);
  endtask

  task automatic test_table_load();
    drain_results();
    write_reg(REG_ROW_WIDTH, 32'd4);
    send_entry(8'd0, 8'd255);
    send_entry(8'd255, 8'd0);
    send_entry(8'h5A, 8'hC3);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'h5A);
  endtask

  task automatic test_row_widths();
    drain_results();
    // zero width acts as one
    write_reg(REG_ROW_WIDTH, 32'd0);
    send_pixel(8'($urandom));
    drain_results();
    write_reg(REG_ROW_WIDTH, 32'd3);
    repeat (3) send_pixel(8'($urandom));
  endtask

  task automatic test_clip_ramp();
    drain_results();
    write_reg(REG_MODE, 32'(MODE_CLIP));
    write_reg(REG_CLIP_LOW, 32'd0);
    write_reg(REG_CLIP_HIGH, 32'd255);
    send_pixel(8'd0);
    send_pixel(8'd128);
    send_pixel(8'd255);
    drain_results();
    write_reg(REG_CLIP_LOW, 32'd10);
    write_reg(REG_CLIP_HIGH, 32'd200);
    send_pixel(8'd10);
    send_pixel(8'd199);
    send_pixel(8'd200);
    drain_results();
    // high of zero cleans to one
    write_reg(REG_CLIP_LOW, 32'd0);
    write_reg(REG_CLIP_HIGH, 32'd0);
    send_pixel(8'd1);
    drain_results();
    // low above high cleans to high-1
    write_reg(REG_CLIP_LOW, 32'd200);
    write_reg(REG_CLIP_HIGH, 32'd100);
    send_pixel(8'd99);
    send_entry(8'($urandom), 8'($urandom));
  endtask

  task automatic test_width_saturation();
    drain_results();
    write_reg(REG_MODE, 32'(MODE_TABLE));
    write_reg(REG_ROW_WIDTH, 32'd8191);
    repeat (3) send_pixel(8'($urandom));
    drain_results();
    write_reg(REG_ROW_WIDTH, 32'd2);
    send_pixel(8'($urandom));
  endtask

  task automatic test_backpressure();
    drain_results();
    write_reg(REG_ROW_WIDTH, 32'd1);
    pace_sender   = 1'b0;
    pace_receiver = 1'b1;
    start_hold    = 1'b1;
    repeat (30) send_pixel(8'($urandom));
    drain_results();
  endtask

  task automatic test_random_traffic();
    int         first;
    int         n;
    logic [7:0] a;
    first = requests_sent;
    while (requests_sent - first < 55) begin
      drain_results();
      pace_sender   = ($urandom_range(0, 3) != 0);
      pace_receiver = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) write_reg(REG_MODE, $urandom_range(0, 1));
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_CLIP_LOW, $urandom_range(0, 2) == 0 ? 32'd255 * $urandom_range(0, 1)
                                                          : 32'($urandom_range(0, 255)));
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_CLIP_HIGH, $urandom_range(0, 2) == 0 ? 32'd255 * $urandom_range(0, 1)
                                                           : 32'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       write_reg(REG_ROW_WIDTH, 32'd0);
          1:       write_reg(REG_ROW_WIDTH, 32'($urandom_range(4096, 8191)));
          2:       write_reg(REG_ROW_WIDTH, 32'($urandom_range(10, 40)));
          default: write_reg(REG_ROW_WIDTH, 32'($urandom_range(1, 9)));
        endcase
      end
      n = $urandom_range(6, 18);
      repeat (n) begin
        if ($urandom_range(0, 99) < 15) begin
          send_entry(8'($urandom), 8'($urandom));
        end else begin
          case ($urandom_range(0, 6))
            0:       a = 8'd0;
            1:       a = 8'd255;
            2:       a = clip_low_q + 8'($urandom_range(0, 2)) - 8'd1;
            3:       a = clip_high_q + 8'($urandom_range(0, 2)) - 8'd1;
            4:       a = last_entry;
            default: a = 8'($urandom);
          endcase
          send_pixel(a);
        end
      end
    end
    pace_sender   = 1'b0;
    pace_receiver = 1'b0;
  endtask

  // receiver: long hold on request, otherwise alternating free and stalled runs while paced
  always @(negedge clk) begin
    if (start_hold) begin
      hold_left  = 150;
      start_hold = 1'b0;
    end
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else if (!pace_receiver) begin
      result_stall <= 1'b0;
    end else begin
      if (stall_run <= 0) begin
        stall_on  = !stall_on;
        stall_run = stall_on ? $urandom_range(1, 4) : $urandom_range(1, 7);
      end
      stall_run--;
      result_stall <= stall_on;
    end
  end

  always @(posedge clk) begin : check_results
    remap_byte_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected result alpha", alpha_out, -1);
      end else begin
        want = expected_bytes.pop_front();
        if (alpha_out !== want.alpha) report_mismatch("alpha_out", alpha_out, want.alpha);
        if (is_padding !== want.pad) report_mismatch("is_padding", is_padding, want.pad);
        if (row_last !== want.last) report_mismatch("row_last", row_last, want.last);
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) remap_lut[i] = 8'(i);
    column_pos  = '0;
    mode_q      = MODE_TABLE;
    clip_low_q  = 8'd0;
    clip_high_q = 8'd255;
    row_width_q = 13'd1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_identity_table();
    test_table_load();
    test_row_widths();
    test_clip_ramp();
    test_width_saturation();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("PASS alpha_mask_table_remap_unit");
    end else begin
      $display("FAIL alpha_mask_table_remap_unit");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL alpha_mask_table_remap_unit");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/amtr_pkg.sv
hdl/amtr_scale.sv
hdl/alpha_mask_table_remap_unit.sv
tb/tb_alpha_mask_table_remap_unit.sv
